FILE: rtl/core/bts_pkg.sv
// Shared constants, item types and helpers for the bilinear texture sampler.
`default_nettype none
package bts_pkg;

  localparam int MAX_DIM = 256;
  localparam int FRAC_BITS = 16;
  localparam int DIM_W = $clog2(MAX_DIM);
  localparam int CFG_W = 9;
  localparam int ADDR_W = 16;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int COLOR_W = 8;
  localparam int OUT_W = 16;
  localparam int WGT_W = 17;
  localparam int FX_W = FRAC_BITS + 1 + DIM_W;
  localparam int SH_DN = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_UP = (FRAC_BITS >= 16) ? 0 : 16 - FRAC_BITS;

  localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1 << 16);
  localparam logic [OUT_W-1:0] FULL_COLOR = 16'hFF00;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_BILINEAR = 2'd1;
  localparam logic [1:0] CMD_NEAREST = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam logic [1:0] REG_WIDTH = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_PRESENT = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [15:0]       texel_index;
    logic [7:0]        texel_red;
    logic [7:0]        texel_green;
    logic [7:0]        texel_blue;
    logic signed [31:0] u_coord;
    logic signed [31:0] v_coord;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0] tex_width;
    logic [CFG_W-1:0] tex_height;
    logic             texture_present;
  } cfg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } texel_t;

  typedef struct packed {
    logic [1:0]             cmd;
    logic                   magenta;
    logic [ADDR_W-1:0]      widx;
    texel_t                 texel;
    logic [3:0][ADDR_W-1:0] addr;
    logic [WGT_W-1:0]       sx;
    logic [WGT_W-1:0]       sy;
  } fetch_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic             magenta;
    logic [WGT_W-1:0] sx;
    logic [WGT_W-1:0] sy;
    texel_t [3:0]     t;
  } quad_t;

  function automatic logic [WGT_W-1:0] to_weight(input logic [FX_W-1:0] d);
    logic [FX_W+WGT_W-1:0] t;
    logic [WGT_W-1:0] w;
    t = {{WGT_W{1'b0}}, d};
    if (FRAC_BITS >= 16) t = t >> SH_DN;
    else t = t << SH_UP;
    w = t[WGT_W-1:0];
    if (w > WGT_ONE) w = WGT_ONE;
    return w;
  endfunction

  function automatic logic [COLOR_W-1:0] chan(input texel_t t, input int c);
    case (c)
      0: chan = t.red;
      1: chan = t.green;
      default: chan = t.blue;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bts_coord.sv
// Coordinate front end: wrap, scale, neighbor selection and store addresses.
`default_nettype none
module bts_coord import bts_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cfg_t     cfg,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output fetch_t        out_data
);

  localparam logic [FX_W:0] HALF = (FX_W+1)'(1 << (FRAC_BITS - 1));
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1 << FRAC_BITS);
  localparam int XI_W = FX_W - FRAC_BITS;
  localparam int PROD_W = 2 * DIM_W + 2;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4 = !v4 || out_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;
  assign out_valid = v4;

  logic [1:0]           s1_cmd, s2_cmd, s3_cmd;
  logic                 s1_mag, s2_mag, s3_mag;
  logic [ADDR_W-1:0]    s1_widx, s2_widx, s3_widx;
  texel_t               s1_texel, s2_texel, s3_texel;
  logic [FRAC_BITS-1:0] s1_fu;
  logic [FRAC_BITS:0]   s1_fv;
  logic [DIM_W-1:0]     s1_wm1, s1_hm1, s2_wm1, s2_hm1;
  logic [DIM_W:0]       s1_wc, s2_wc, s3_wc;
  logic [FX_W-1:0]      s2_fx, s2_fy;
  logic [DIM_W-1:0]     s3_x0, s3_x1, s3_y0, s3_y1;
  logic [WGT_W-1:0]     s3_sx, s3_sy;

  logic [DIM_W:0]   w_cl, h_cl;
  logic [XI_W-1:0]  xi, yi;
  logic [DIM_W-1:0] x0, y0, x1, y1, xr, yr;
  logic [FX_W:0]    xs, ys;
  logic [XI_W:0]    xri, yri;
  logic [FX_W-1:0]  dx, dy;

  always_comb begin
    w_cl = (DIM_W+1)'(cfg.tex_width);
    if (cfg.tex_width == '0) w_cl = (DIM_W+1)'(1);
    else if (cfg.tex_width > MAX_DIM) w_cl = (DIM_W+1)'(MAX_DIM);
    h_cl = (DIM_W+1)'(cfg.tex_height);
    if (cfg.tex_height == '0) h_cl = (DIM_W+1)'(1);
    else if (cfg.tex_height > MAX_DIM) h_cl = (DIM_W+1)'(MAX_DIM);
  end

  always_comb begin
    xi = s2_fx[FX_W-1:FRAC_BITS];
    yi = s2_fy[FX_W-1:FRAC_BITS];
    x0 = (xi > s2_wm1) ? s2_wm1 : xi[DIM_W-1:0];
    y0 = (yi > s2_hm1) ? s2_hm1 : yi[DIM_W-1:0];
    x1 = (x0 == s2_wm1) ? s2_wm1 : DIM_W'(x0 + 1'b1);
    y1 = (y0 == s2_hm1) ? s2_hm1 : DIM_W'(y0 + 1'b1);
    dx = s2_fx - FX_W'({x0, {FRAC_BITS{1'b0}}});
    dy = s2_fy - FX_W'({y0, {FRAC_BITS{1'b0}}});
    xs = {1'b0, s2_fx} + HALF;
    ys = {1'b0, s2_fy} + HALF;
    xri = xs[FX_W:FRAC_BITS];
    yri = ys[FX_W:FRAC_BITS];
    xr = (xri > s2_wm1) ? s2_wm1 : xri[DIM_W-1:0];
    yr = (yri > s2_hm1) ? s2_hm1 : yri[DIM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid && (in_data.cmd != CMD_NONE);
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_cmd <= in_data.cmd;
      s1_mag <= !cfg.texture_present;
      s1_widx <= in_data.texel_index;
      s1_texel <= '{in_data.texel_red, in_data.texel_green, in_data.texel_blue};
      s1_fu <= in_data.u_coord[FRAC_BITS-1:0];
      s1_fv <= ONE - {1'b0, in_data.v_coord[FRAC_BITS-1:0]};
      s1_wm1 <= DIM_W'(w_cl - 1'b1);
      s1_hm1 <= DIM_W'(h_cl - 1'b1);
      s1_wc <= w_cl;
    end
    if (en2) begin
      s2_cmd <= s1_cmd;
      s2_mag <= s1_mag;
      s2_widx <= s1_widx;
      s2_texel <= s1_texel;
      s2_fx <= FX_W'(s1_fu) * FX_W'(s1_wm1);
      s2_fy <= FX_W'(s1_fv) * FX_W'(s1_hm1);
      s2_wm1 <= s1_wm1;
      s2_hm1 <= s1_hm1;
      s2_wc <= s1_wc;
    end
    if (en3) begin
      s3_cmd <= s2_cmd;
      s3_mag <= s2_mag;
      s3_widx <= s2_widx;
      s3_texel <= s2_texel;
      s3_wc <= s2_wc;
      s3_sx <= to_weight(dx);
      s3_sy <= to_weight(dy);
      if (s2_cmd == CMD_NEAREST) begin
        s3_x0 <= xr;
        s3_y0 <= yr;
      end else begin
        s3_x0 <= x0;
        s3_y0 <= y0;
      end
      s3_x1 <= x1;
      s3_y1 <= y1;
    end
    if (en4) begin
      out_data.cmd <= s3_cmd;
      out_data.magenta <= s3_mag;
      out_data.widx <= s3_widx;
      out_data.texel <= s3_texel;
      out_data.sx <= s3_sx;
      out_data.sy <= s3_sy;
      out_data.addr[0] <= ADDR_W'(PROD_W'(s3_y0) * PROD_W'(s3_wc) + PROD_W'(s3_x0));
      out_data.addr[1] <= ADDR_W'(PROD_W'(s3_y0) * PROD_W'(s3_wc) + PROD_W'(s3_x1));
      out_data.addr[2] <= ADDR_W'(PROD_W'(s3_y1) * PROD_W'(s3_wc) + PROD_W'(s3_x0));
      out_data.addr[3] <= ADDR_W'(PROD_W'(s3_y1) * PROD_W'(s3_wc) + PROD_W'(s3_x1));
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/bts_store.sv
// Texel store: four replicated RAMs, one write and four neighbor reads per beat.
`default_nettype none
module bts_store import bts_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire fetch_t in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output quad_t       out_data
);

  logic v5, en5, wr;
  texel_t rd [4];

  assign en5 = !v5 || out_ready;
  assign in_ready = en5;
  assign out_valid = v5;
  assign wr = en5 && in_valid && (in_data.cmd == CMD_WRITE);

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en5) v5 <= in_valid && (in_data.cmd != CMD_WRITE);
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      out_data.cmd <= in_data.cmd;
      out_data.magenta <= in_data.magenta;
      out_data.sx <= in_data.sx;
      out_data.sy <= in_data.sy;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    texel_t mem [STORE_DEPTH];
    always_ff @(posedge clk) begin
      if (wr) mem[in_data.widx] <= in_data.texel;
      if (en5) rd[k] <= mem[in_data.addr[k]];
    end
    assign out_data.t[k] = rd[k];
  end

endmodule
`default_nettype wire

FILE: rtl/core/bts_blend.sv
// Blend back end: horizontal lerp, split vertical lerp and result select.
`default_nettype none
module bts_blend import bts_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire quad_t in_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_item_t  out_data
);

  localparam int TOP_W = COLOR_W + WGT_W;
  localparam int HI_W = TOP_W - 16;
  localparam int LO_P_W = 16 + WGT_W;
  localparam int HI_P_W = HI_W + WGT_W;
  localparam int TOT_W = TOP_W + WGT_W + 1;

  logic v6, v7, v8, en6, en7, en8;

  assign en8 = !v8 || out_ready;
  assign en7 = !v7 || en8;
  assign en6 = !v6 || en7;
  assign in_ready = en6;
  assign out_valid = v8;

  logic [1:0]         s6_cmd, s7_cmd;
  logic               s6_mag, s7_mag;
  logic [WGT_W-1:0]   s6_sy;
  texel_t             s6_near, s7_near;
  logic [TOP_W-1:0]   s6_top [3];
  logic [TOP_W-1:0]   s6_bot [3];
  logic [LO_P_W-1:0]  s7_tlo [3];
  logic [LO_P_W-1:0]  s7_blo [3];
  logic [HI_P_W-1:0]  s7_thi [3];
  logic [HI_P_W-1:0]  s7_bhi [3];

  logic [WGT_W-1:0] wx, wy;
  logic [TOT_W-1:0] total [3];
  logic [OUT_W-1:0] lerp [3];

  assign wx = WGT_ONE - in_data.sx;
  assign wy = WGT_ONE - s6_sy;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      total[c] = (TOT_W'(s7_thi[c]) + TOT_W'(s7_bhi[c])) << 16;
      total[c] = total[c] + TOT_W'(s7_tlo[c]) + TOT_W'(s7_blo[c]);
      lerp[c] = total[c][24 +: OUT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else begin
      if (en6) v6 <= in_valid;
      if (en7) v7 <= v6;
      if (en8) v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_cmd <= in_data.cmd;
      s6_mag <= in_data.magenta;
      s6_sy <= in_data.sy;
      s6_near <= in_data.t[0];
      for (int c = 0; c < 3; c++) begin
        s6_top[c] <= TOP_W'(chan(in_data.t[0], c)) * TOP_W'(wx)
                   + TOP_W'(chan(in_data.t[1], c)) * TOP_W'(in_data.sx);
        s6_bot[c] <= TOP_W'(chan(in_data.t[2], c)) * TOP_W'(wx)
                   + TOP_W'(chan(in_data.t[3], c)) * TOP_W'(in_data.sx);
      end
    end
    if (en7) begin
      s7_cmd <= s6_cmd;
      s7_mag <= s6_mag;
      s7_near <= s6_near;
      for (int c = 0; c < 3; c++) begin
        s7_tlo[c] <= LO_P_W'(s6_top[c][15:0]) * LO_P_W'(wy);
        s7_blo[c] <= LO_P_W'(s6_bot[c][15:0]) * LO_P_W'(s6_sy);
        s7_thi[c] <= HI_P_W'(s6_top[c][TOP_W-1:16]) * HI_P_W'(wy);
        s7_bhi[c] <= HI_P_W'(s6_bot[c][TOP_W-1:16]) * HI_P_W'(s6_sy);
      end
    end
    if (en8) begin
      if (s7_mag) begin
        out_data <= '{FULL_COLOR, '0, FULL_COLOR};
      end else if (s7_cmd == CMD_NEAREST) begin
        out_data <= '{{s7_near.red, 8'h00}, {s7_near.green, 8'h00},
                      {s7_near.blue, 8'h00}};
      end else begin
        out_data <= '{lerp[0], lerp[1], lerp[2]};
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/bilinear_texture_sampler.sv
// Top level of the bilinear texture sampler: registers and pipeline stitching.
// A sample beat passes in order through the registered coordinate, store and blend stages.
// Throughput: one beat per cycle; a stage holds only while its successor is full.
// Texel writes take effect in the store stage, in order with samples, and give no result.
// Synchronous reset clears the valid bits and sets width 1, height 1, no texture.
// The texel store is not cleared by reset.
`default_nettype none
module bilinear_texture_sampler import bts_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  cfg_t   cfg;
  fetch_t fetch;
  quad_t  quad;
  logic   fetch_valid, fetch_ready, quad_valid, quad_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tex_width <= CFG_W'(1);
      cfg.tex_height <= CFG_W'(1);
      cfg.texture_present <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH: cfg.tex_width <= cfg_data;
        REG_HEIGHT: cfg.tex_height <= cfg_data;
        REG_PRESENT: cfg.texture_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bts_coord u_coord (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(fetch_valid), .out_ready(fetch_ready), .out_data(fetch)
  );

  bts_store u_store (
    .clk(clk), .rst(rst),
    .in_valid(fetch_valid), .in_ready(fetch_ready), .in_data(fetch),
    .out_valid(quad_valid), .out_ready(quad_ready), .out_data(quad)
  );

  bts_blend u_blend (
    .clk(clk), .rst(rst),
    .in_valid(quad_valid), .in_ready(quad_ready), .in_data(quad),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

endmodule
`default_nettype wire

FILE: rtl/core/bts_checker.sv
// Port-level checker for the bilinear texture sampler and its bind.
`default_nettype none
module bts_port_props import bts_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output stage");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.out_red <= FULL_COLOR && out_data.out_green <= FULL_COLOR
                  && out_data.out_blue <= FULL_COLOR)
    else $error("result color above full scale");

endmodule

bind bilinear_texture_sampler bts_port_props u_bts_port_props (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
